// ----- hw/rtl/lqm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_pkg
// Shared constants, codes and control bundles of the linked queue manager.
// ----------------------------------------------------------------------------
package lqm_pkg;

    localparam int NODES    = 16;
    localparam int QUEUES   = 4;
    localparam int NODE_W   = $clog2(NODES);
    localparam int QUEUE_W  = $clog2(QUEUES);
    localparam int COUNT_W  = $clog2(NODES + 1);
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam int IN_FIELD_W  = FUNC_W + QUEUE_W + NODE_W;
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int RES_W       = STATUS_W + COUNT_W + NODE_W + 1;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2
    } lqm_func_e;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_QUEUED = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_ABSENT = 2'd3
    } lqm_status_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_APPEND_TAIL,
        ST_UNLINK,
        ST_PUBLISH
    } lqm_state_e;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;          // capture the request
        logic check;         // latch status, read link memories
        logic wr_self;       // first node: link to itself, take the head
        logic wr_head_pair;  // next[n] = head, prev[head] = n
        logic wr_tail_pair;  // next[tail] = n, prev[n] = tail
        logic unlink;        // next[pv] = nx, prev[nx] = pv
        logic book_append;   // count up, mark node, record owner
        logic book_remove;   // count down, clear node, move head
        logic publish;       // load the result register
    } lqm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_append;
        logic is_remove;
        logic ok;
        logic cnt_zero;
        logic cnt_one;
        logic out_stall;
    } lqm_sts_t;

    // Result fields, status in the lowest bits
    typedef struct packed {
        logic                head_valid;
        logic [NODE_W-1:0]   head_node;
        logic [COUNT_W-1:0]  queue_len;
        logic [STATUS_W-1:0] status;
    } lqm_result_t;

endpackage

// ----- hw/rtl/linked_queue_manager_top.sv -----
// A request is taken in idle, checked, then published. An append to a non-empty
// queue adds a tail-write step, as each link memory has one write port; a remove
// that leaves nodes behind adds an unlink step on the neighbours read at check.
// One request at a time. A waiting result does not block acceptance of the next
// request; that request holds in publish until the result register is free.
// Reset: rst_n clears all queues to empty and drops m_tvalid; link memories
// and owner records are written before they are read and need no clearing.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_queue_manager_top
// Circular doubly linked queues over a shared pool of node ids.
// ----------------------------------------------------------------------------
module linked_queue_manager_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lqm_pkg::IN_TDATA_W-1:0]     s_tdata,   // func[1:0], queue_sel[3:2], node[7:4]
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lqm_pkg::OUT_TDATA_W-1:0]    m_tdata    // status[1:0], queue_len[6:2],
                                                          // head_node[10:7], head_valid[11]
);

    import lqm_pkg::*;

    lqm_cmd_t    cmd;
    lqm_sts_t    sts;
    lqm_result_t result;

    // Controller walks each request through check, optional link writes
    // and publish; it takes a new request only from idle.
    lqm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath holds the queue heads, counters, membership flags and owner
    // records, plus the next/prev link memories and the result register.
    lqm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .result    (result)
    );

    // pad the result fields to whole bytes
    assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, result};

endmodule

// ----- hw/rtl/lqm_link_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_link_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lqm_link_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lqm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_ctrl
// Sequencer: one request at a time through check, link writes and publish.
// ----------------------------------------------------------------------------
module lqm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lqm_pkg::lqm_sts_t sts,
    output lqm_pkg::lqm_cmd_t cmd
);

    import lqm_pkg::*;

    lqm_state_e state_reg;
    lqm_state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_PUBLISH;
                if (sts.is_append && sts.ok)
                begin
                    if (sts.cnt_zero)
                    begin
                        cmd.wr_self     = 1'b1;
                        cmd.book_append = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_head_pair = 1'b1;
                        state_next       = ST_APPEND_TAIL;
                    end
                end
                else if (sts.is_remove && sts.ok)
                begin
                    if (sts.cnt_one)
                    begin
                        cmd.book_remove = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_UNLINK;
                    end
                end
            end
            ST_APPEND_TAIL:
            begin
                cmd.wr_tail_pair = 1'b1;
                cmd.book_append  = 1'b1;
                state_next       = ST_PUBLISH;
            end
            ST_UNLINK:
            begin
                cmd.unlink      = 1'b1;
                cmd.book_remove = 1'b1;
                state_next      = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                // hold until the result register is free
                if (!sts.out_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lqm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_datapath
// Request registers, queue bookkeeping, link memories and result register.
// ----------------------------------------------------------------------------
module lqm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lqm_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                m_tready,
    input  lqm_pkg::lqm_cmd_t                   cmd,
    output lqm_pkg::lqm_sts_t                   sts,
    output logic                                out_valid,
    output lqm_pkg::lqm_result_t                result
);

    import lqm_pkg::*;

    // request
    logic [FUNC_W-1:0]  func_reg;
    logic [QUEUE_W-1:0] qsel_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [STATUS_W-1:0] status_reg;

    // bookkeeping
    logic [NODE_W-1:0]  head_reg  [QUEUES];
    logic [COUNT_W-1:0] count_reg [QUEUES];
    logic               linked_reg [NODES];
    logic [QUEUE_W-1:0] owner_reg [NODES];

    logic                out_valid_reg;
    lqm_result_t         result_reg;

    logic [COUNT_W-1:0]  cnt_cur;
    logic [NODE_W-1:0]   head_cur;
    logic [STATUS_W-1:0] check_code;
    logic                is_append;
    logic                is_remove;

    // link memories
    logic                next_we;
    logic [NODE_W-1:0]   next_waddr;
    logic [NODE_W-1:0]   next_wdata;
    logic [NODE_W-1:0]   next_rdata;
    logic                prev_we;
    logic [NODE_W-1:0]   prev_waddr;
    logic [NODE_W-1:0]   prev_wdata;
    logic [NODE_W-1:0]   prev_raddr;
    logic [NODE_W-1:0]   prev_rdata;

    assign cnt_cur   = count_reg[qsel_reg];
    assign head_cur  = head_reg[qsel_reg];
    assign is_append = (func_reg == FUNC_APPEND);
    assign is_remove = (func_reg == FUNC_REMOVE);

    always_comb
    begin
        check_code = STAT_OK;
        case (func_reg)
            FUNC_APPEND:
            begin
                if (linked_reg[node_reg])
                begin
                    check_code = STAT_QUEUED;
                end
            end
            FUNC_REMOVE:
            begin
                if (cnt_cur == '0)
                begin
                    check_code = STAT_EMPTY;
                end
                else if (!linked_reg[node_reg] || (owner_reg[node_reg] != qsel_reg))
                begin
                    check_code = STAT_ABSENT;
                end
            end
            default:
            begin
                check_code = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        sts.is_append = is_append;
        sts.is_remove = is_remove;
        sts.ok        = (check_code == STAT_OK);
        sts.cnt_zero  = (cnt_cur == '0);
        sts.cnt_one   = (cnt_cur == COUNT_W'(1));
        sts.out_stall = out_valid_reg && !m_tready;
    end

    // one write per memory per step; the read data holds between checks
    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = node_reg;
        next_wdata = node_reg;
        prev_we    = 1'b0;
        prev_waddr = node_reg;
        prev_wdata = node_reg;
        if (cmd.wr_self)
        begin
            next_we = 1'b1;
            prev_we = 1'b1;
        end
        else if (cmd.wr_head_pair)
        begin
            next_we    = 1'b1;
            next_wdata = head_cur;
            prev_we    = 1'b1;
            prev_waddr = head_cur;
        end
        else if (cmd.wr_tail_pair)
        begin
            next_we    = 1'b1;
            next_waddr = prev_rdata;
            prev_we    = 1'b1;
            prev_wdata = prev_rdata;
        end
        else if (cmd.unlink)
        begin
            next_we    = 1'b1;
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
            prev_we    = 1'b1;
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
        end
    end

    // append reads the tail behind the head, remove reads the node's neighbors
    assign prev_raddr = is_append ? head_cur : node_reg;

    lqm_link_ram #(
        .DEPTH (NODES),
        .WIDTH (NODE_W)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (cmd.check),
        .raddr (node_reg),
        .rdata (next_rdata)
    );

    lqm_link_ram #(
        .DEPTH (NODES),
        .WIDTH (NODE_W)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (cmd.check),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tdata[FUNC_W-1:0];
            qsel_reg <= s_tdata[FUNC_W +: QUEUE_W];
            node_reg <= s_tdata[FUNC_W + QUEUE_W +: NODE_W];
        end
        if (cmd.check)
        begin
            status_reg <= check_code;
        end
        if (cmd.book_append)
        begin
            owner_reg[node_reg] <= qsel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            for (int i = 0; i < NODES; i++)
            begin
                linked_reg[i] <= 1'b0;
            end
        end
        else if (cmd.book_append)
        begin
            count_reg[qsel_reg]  <= cnt_cur + COUNT_W'(1);
            linked_reg[node_reg] <= 1'b1;
            if (cmd.wr_self)
            begin
                head_reg[qsel_reg] <= node_reg;
            end
        end
        else if (cmd.book_remove)
        begin
            count_reg[qsel_reg]  <= cnt_cur - COUNT_W'(1);
            linked_reg[node_reg] <= 1'b0;
            if (cnt_cur == COUNT_W'(1))
            begin
                head_reg[qsel_reg] <= '0;
            end
            else if (head_cur == node_reg)
            begin
                head_reg[qsel_reg] <= next_rdata;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            result_reg.status     <= status_reg;
            result_reg.queue_len  <= cnt_cur;
            result_reg.head_valid <= (cnt_cur != '0);
            result_reg.head_node  <= (cnt_cur != '0) ? head_cur : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ----- hw/rtl/lqm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_checker
// Port-level checks of the linked queue manager, bound to the top level.
// ----------------------------------------------------------------------------
module lqm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lqm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    import lqm_pkg::*;

    // one request in flight: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // a result held back stays valid and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // head_valid agrees with a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W + COUNT_W + NODE_W]
                      == (m_tdata[STATUS_W +: COUNT_W] != '0)))
        else $error("head_valid disagrees with queue_len");

    // the length never exceeds the pool, and an empty queue reports head 0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[STATUS_W +: COUNT_W] <= COUNT_W'(NODES))
                      && (m_tdata[STATUS_W + COUNT_W + NODE_W]
                          || (m_tdata[STATUS_W + COUNT_W +: NODE_W] == '0))))
        else $error("bad length or head on an empty queue");

endmodule

bind linked_queue_manager_top lqm_checker u_lqm_checker (.*);

// ----- tb/tb_linked_queue_manager_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_queue_manager_top
// Self-checking bench for the linked queue manager. A behavioral copy of the
// queue rings, owner records and counters predicts the status, length and
// head of every request; a checker compares each result field by field.
// Directed cases come first, then fill/drain sequences and random traffic
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_linked_queue_manager_top;

    import lqm_pkg::*;

    // Function code three has no name in the package; the block treats it as a query.
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        lqm_result_t          res;
        logic [IN_TDATA_W-1:0] req;
    } queue_op_expect_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;   // func[1:0], queue_sel[3:2], node[7:4]
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;        // status[1:0], queue_len[6:2],
                                             // head_node[10:7], head_valid[11]

    // Behavioral copy of the block state
    logic [NODE_W-1:0]   next_ring [NODES];
    logic [NODE_W-1:0]   prev_ring [NODES];
    logic                in_queue  [NODES];
    logic [QUEUE_W-1:0]  owner     [NODES];
    logic [NODE_W-1:0]   q_head    [QUEUES];
    logic [COUNT_W-1:0]  q_count   [QUEUES];

    queue_op_expect_t pending_results[$];

    int  errors = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  peak_len = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;      // no gaps and no stalls while set

    linked_queue_manager_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: end the run if the block stops making progress
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("tb_linked_queue_manager_top: done, errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string field, input int exp_v, input int got_v,
                                   input logic [IN_TDATA_W-1:0] req);
        $display("mismatch at result %0d (request 0x%02h): %s expected %0d, got %0d",
                 results_checked, req, field, exp_v, got_v);
        errors++;
    endtask

    // Apply one request to the behavioral state and return the result it yields
    function automatic lqm_result_t predict_queue_op(input logic [FUNC_W-1:0] f,
                                                     input logic [QUEUE_W-1:0] q,
                                                     input logic [NODE_W-1:0] n);
        lqm_result_t        res;
        logic [NODE_W-1:0]  h;
        logic [NODE_W-1:0]  t;
        logic [NODE_W-1:0]  nx;
        logic [NODE_W-1:0]  pv;
        res = '0;
        res.status = STAT_OK;
        case (f)
            FUNC_APPEND:
            begin
                if (in_queue[n])
                    res.status = STAT_QUEUED;
                else
                begin
                    if (q_count[q] == 0)
                    begin
                        q_head[q]    = n;
                        next_ring[n] = n;
                        prev_ring[n] = n;
                    end
                    else
                    begin
                        h            = q_head[q];
                        t            = prev_ring[h];
                        prev_ring[n] = t;
                        next_ring[n] = h;
                        next_ring[t] = n;
                        prev_ring[h] = n;
                    end
                    q_count[q]  = q_count[q] + COUNT_W'(1);
                    in_queue[n] = 1'b1;
                    owner[n]    = q;
                end
            end
            FUNC_REMOVE:
            begin
                if (q_count[q] == 0)
                    res.status = STAT_EMPTY;
                else if (!in_queue[n] || owner[n] != q)
                    res.status = STAT_ABSENT;
                else
                begin
                    if (q_count[q] == 1)
                        q_head[q] = '0;
                    else
                    begin
                        nx            = next_ring[n];
                        pv            = prev_ring[n];
                        next_ring[pv] = nx;
                        prev_ring[nx] = pv;
                        if (q_head[q] == n)
                            q_head[q] = nx;
                    end
                    q_count[q]  = q_count[q] - COUNT_W'(1);
                    in_queue[n] = 1'b0;
                end
            end
            default: ;   // query and the spare code change nothing
        endcase
        res.queue_len  = q_count[q];
        res.head_valid = (q_count[q] != 0);
        res.head_node  = (q_count[q] != 0) ? q_head[q] : '0;
        if (int'(q_count[q]) > peak_len)
            peak_len = int'(q_count[q]);
        return res;
    endfunction

    // Drive one request, hold it until accepted, then record its expected result
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [QUEUE_W-1:0] q,
                                input logic [NODE_W-1:0] n);
        int               gap;
        queue_op_expect_t item;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {n, q, f};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item.req = {n, q, f};
        item.res = predict_queue_op(f, q, n);
        pending_results.push_back(item);
        requests_sent++;
    endtask

    // Compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        queue_op_expect_t exp_item;
        lqm_result_t      got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = lqm_result_t'(m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("unexpected result 0x%03h with nothing outstanding", got);
                errors++;
            end
            else
            begin
                exp_item = pending_results.pop_front();
                if (got.status !== exp_item.res.status)
                    report_mismatch("status", int'(exp_item.res.status),
                                    int'(got.status), exp_item.req);
                if (got.queue_len !== exp_item.res.queue_len)
                    report_mismatch("queue_len", int'(exp_item.res.queue_len),
                                    int'(got.queue_len), exp_item.req);
                if (got.head_node !== exp_item.res.head_node)
                    report_mismatch("head_node", int'(exp_item.res.head_node),
                                    int'(got.head_node), exp_item.req);
                if (got.head_valid !== exp_item.res.head_valid)
                    report_mismatch("head_valid", int'(exp_item.res.head_valid),
                                    int'(got.head_valid), exp_item.req);
                results_checked++;
            end
        end
    end

    // Result side: ready stretches broken by stalls of random length
    initial
    begin
        int hold;
        int stall;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 1 : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (hold) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    function automatic int pick_free_node();
        int cand[$];
        for (int i = 0; i < NODES; i++)
            if (!in_queue[i])
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function automatic int pick_queued_node();
        int cand[$];
        for (int i = 0; i < NODES; i++)
            if (in_queue[i])
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Every status code, head/middle/tail removal, the spare code and both node extremes
    task automatic test_directed_cases();
        send_request(FUNC_QUERY,  2'd0, 4'd0);
        send_request(FUNC_QUERY,  2'd3, 4'd15);
        send_request(FUNC_REMOVE, 2'd0, 4'd0);     // empty queue wins
        send_request(FUNC_APPEND, 2'd0, 4'd0);
        send_request(FUNC_APPEND, 2'd0, 4'd15);
        send_request(FUNC_APPEND, 2'd0, 4'd5);
        send_request(FUNC_APPEND, 2'd1, 4'd5);     // already held by another queue
        send_request(FUNC_APPEND, 2'd0, 4'd0);     // already held by this queue
        send_request(FUNC_REMOVE, 2'd0, 4'd7);     // never queued
        send_request(FUNC_APPEND, 2'd1, 4'd7);
        send_request(FUNC_REMOVE, 2'd1, 4'd0);     // owned by queue 0
        send_request(FUNC_SPARE,  2'd0, 4'd9);
        send_request(FUNC_REMOVE, 2'd0, 4'd5);     // tail
        send_request(FUNC_REMOVE, 2'd0, 4'd0);     // head moves on
        send_request(FUNC_APPEND, 2'd0, 4'd0);
        send_request(FUNC_APPEND, 2'd0, 4'd5);
        send_request(FUNC_REMOVE, 2'd0, 4'd0);     // middle
        send_request(FUNC_REMOVE, 2'd0, 4'd15);
        send_request(FUNC_REMOVE, 2'd0, 4'd5);     // last node, queue goes empty
        send_request(FUNC_APPEND, 2'd3, 4'd15);
        send_request(FUNC_QUERY,  2'd3, 4'd0);
        send_request(FUNC_REMOVE, 2'd3, 4'd15);
        send_request(FUNC_REMOVE, 2'd1, 4'd7);
        send_request(FUNC_SPARE,  2'd3, 4'd0);
    endtask

    // Fill one queue with the whole pool in random order, overfill, then drain it
    task automatic test_fill_drain(input logic [QUEUE_W-1:0] q, input bit by_head);
        int order[NODES];
        int j;
        int tmp;
        for (int i = 0; i < NODES; i++)
            order[i] = i;
        for (int i = NODES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NODES; i++)
            send_request(FUNC_APPEND, q, NODE_W'(order[i]));
        send_request(FUNC_APPEND, q, NODE_W'(order[0]));
        send_request(FUNC_QUERY, q, 4'd0);
        if (by_head)
        begin
            while (q_count[q] != 0)
                send_request(FUNC_REMOVE, q, q_head[q]);
        end
        else
        begin
            for (int i = NODES - 1; i >= 0; i--)
                send_request(FUNC_REMOVE, q, NODE_W'(order[i]));
        end
        send_request(FUNC_REMOVE, q, NODE_W'(order[0]));
    endtask

    // Mostly well-formed traffic built from the current state, the rest raw noise
    task automatic test_random_traffic(input int count);
        int r;
        int n;
        logic [IN_TDATA_W-1:0] raw;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
            begin
                n = pick_free_node();
                if (n < 0)
                    send_request(FUNC_QUERY, QUEUE_W'($urandom_range(0, QUEUES - 1)), 4'd0);
                else
                    send_request(FUNC_APPEND, QUEUE_W'($urandom_range(0, QUEUES - 1)),
                                 NODE_W'(n));
            end
            else if (r < 78)
            begin
                n = pick_queued_node();
                if (n < 0)
                    send_request(FUNC_REMOVE, QUEUE_W'($urandom_range(0, QUEUES - 1)),
                                 NODE_W'($urandom_range(0, NODES - 1)));
                else
                    send_request(FUNC_REMOVE, owner[n], NODE_W'(n));
            end
            else if (r < 84)
                send_request(($urandom_range(0, 1) != 0) ? FUNC_QUERY : FUNC_SPARE,
                             QUEUE_W'($urandom_range(0, QUEUES - 1)),
                             NODE_W'($urandom_range(0, NODES - 1)));
            else
            begin
                raw = IN_TDATA_W'($urandom_range(0, 255));
                send_request(raw[1:0], raw[3:2], raw[7:4]);
            end
        end
    endtask

    // Random traffic with the request and result sides both running flat out
    task automatic test_back_to_back(input int count);
        quiet = 1'b1;
        test_random_traffic(count);
        quiet = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < NODES; i++)
        begin
            next_ring[i] = '0;
            prev_ring[i] = '0;
            in_queue[i]  = 1'b0;
            owner[i]     = '0;
        end
        for (int i = 0; i < QUEUES; i++)
        begin
            q_head[i]  = '0;
            q_count[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_drain(2'd2, 1'b0);
        test_fill_drain(2'd3, 1'b1);
        test_random_traffic(1000);
        test_back_to_back(120);
        test_fill_drain(2'd0, 1'b1);

        // Drop valid, drain the outstanding results, then let the pipeline settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests over %0d queues, %0d results checked, peak length %0d",
                 requests_sent, QUEUES, results_checked, peak_len);
        if (errors == 0)
            $display("tb_linked_queue_manager_top: done, clean");
        else
            $display("tb_linked_queue_manager_top: done, errors");
        $finish;
    end

endmodule
